[rtl/core/jsu_pkg.sv]
// Shared types and codes for the JSON string unescape core.
// Depends on nothing; every module of the core imports it.
package jsu_pkg;

    localparam int GROUP_DEPTH = 4;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_START = 2'd1,
        OP_END   = 2'd2,
        OP_RSVD  = 2'd3
    } jsu_op_t;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_CLOSED = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_RSVD   = 2'd3
    } jsu_kind_t;

    typedef enum logic [2:0] {
        CAUSE_NONE      = 3'd0,
        CAUSE_NO_QUOTE  = 3'd1,
        CAUSE_CONTROL   = 3'd2,
        CAUSE_BAD_ESC   = 3'd3,
        CAUSE_BAD_HEX   = 3'd4,
        CAUSE_NO_LOW    = 3'd5,
        CAUSE_BAD_LOW   = 3'd6,
        CAUSE_TEXT_END  = 3'd7
    } jsu_cause_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;  // d800..dbff
    localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;  // dc00..dfff
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] in_byte;
    } jsu_in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [2:0] error_cause;
        logic       last;
    } jsu_out_t;

    // One result before the last flag is attached.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] cause;
    } jsu_entry_t;

    // All results caused by one request, entry 0 first.
    typedef struct packed {
        logic [2:0]                       count;
        jsu_entry_t [GROUP_DEPTH-1:0]     entry;
    } jsu_group_t;

endpackage

[rtl/core/jsu_parser.sv]
// Parser state and combinational decode of one request into a result group.
// Depends on jsu_pkg.
module jsu_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  jsu_pkg::jsu_in_t    item,
    output jsu_pkg::jsu_group_t group
);
    import jsu_pkg::*;

    typedef enum logic [3:0] {
        PH_WAIT  = 4'd0,
        PH_BODY  = 4'd1,
        PH_ESC   = 4'd2,
        PH_HEX1  = 4'd3,
        PH_LOWBS = 4'd4,
        PH_LOWU  = 4'd5,
        PH_HEX2  = 4'd6,
        PH_DONE  = 4'd7,
        PH_DEAD  = 4'd8
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] hex_accum_reg, hex_accum_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [9:0]  high_half_reg, high_half_next;

    logic        hex_ok;
    logic [3:0]  hex_digit;
    logic [15:0] hex_new;
    logic [20:0] pair_cp;

    function automatic jsu_entry_t data_entry(input logic [7:0] b);
        jsu_entry_t e;
        e.kind  = KIND_DATA;
        e.data  = b;
        e.cause = CAUSE_NONE;
        return e;
    endfunction

    function automatic jsu_group_t one_entry(input jsu_entry_t e);
        jsu_group_t g;
        g          = '0;
        g.count    = 3'd1;
        g.entry[0] = e;
        return g;
    endfunction

    function automatic jsu_group_t error_group(input jsu_cause_t c);
        jsu_entry_t e;
        e.kind  = KIND_ERROR;
        e.data  = 8'h00;
        e.cause = c;
        return one_entry(e);
    endfunction

    function automatic jsu_group_t utf8_group(input logic [20:0] cp);
        jsu_group_t g;
        g = '0;
        if (cp < 21'h80) begin
            g.count    = 3'd1;
            g.entry[0] = data_entry(cp[7:0]);
        end
        else if (cp < 21'h800) begin
            g.count    = 3'd2;
            g.entry[0] = data_entry({3'b110, cp[10:6]});
            g.entry[1] = data_entry({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000) begin
            g.count    = 3'd3;
            g.entry[0] = data_entry({4'b1110, cp[15:12]});
            g.entry[1] = data_entry({2'b10, cp[11:6]});
            g.entry[2] = data_entry({2'b10, cp[5:0]});
        end
        else begin
            g.count    = 3'd4;
            g.entry[0] = data_entry({5'b11110, cp[20:18]});
            g.entry[1] = data_entry({2'b10, cp[17:12]});
            g.entry[2] = data_entry({2'b10, cp[11:6]});
            g.entry[3] = data_entry({2'b10, cp[5:0]});
        end
        return g;
    endfunction

    always_comb
    begin
        hex_ok    = 1'b1;
        hex_digit = 4'd0;
        if (item.in_byte >= 8'h30 && item.in_byte <= 8'h39)
        begin
            hex_digit = item.in_byte[3:0];
        end
        else if ((item.in_byte >= 8'h61 && item.in_byte <= 8'h66) ||
                 (item.in_byte >= 8'h41 && item.in_byte <= 8'h46))
        begin
            hex_digit = item.in_byte[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign hex_new = {hex_accum_reg[11:0], hex_digit};
    assign pair_cp = SUPP_BASE + {1'b0, high_half_reg, hex_new[9:0]};

    always_comb
    begin
        phase_next     = phase_reg;
        hex_accum_next = hex_accum_reg;
        hex_count_next = hex_count_reg;
        high_half_next = high_half_reg;
        group          = '0;

        case (jsu_op_t'(item.opcode))
            OP_START:
            begin
                phase_next     = PH_WAIT;
                hex_accum_next = '0;
                hex_count_next = '0;
                high_half_next = '0;
            end
            OP_END:
            begin
                if (phase_reg == PH_WAIT)
                begin
                    group      = error_group(CAUSE_NO_QUOTE);
                    phase_next = PH_DEAD;
                end
                else if (phase_reg != PH_DONE && phase_reg != PH_DEAD)
                begin
                    group      = error_group(CAUSE_TEXT_END);
                    phase_next = PH_DEAD;
                end
            end
            OP_BYTE:
            begin
                case (phase_reg)
                    PH_WAIT:
                    begin
                        if (item.in_byte == CH_QUOTE)
                        begin
                            phase_next = PH_BODY;
                        end
                        else if (item.in_byte != 8'h20 && item.in_byte != 8'h0a &&
                                 item.in_byte != 8'h0d && item.in_byte != 8'h09)
                        begin
                            group      = error_group(CAUSE_NO_QUOTE);
                            phase_next = PH_DEAD;
                        end
                    end
                    PH_BODY:
                    begin
                        if (item.in_byte == CH_QUOTE)
                        begin
                            group                = '0;
                            group.count          = 3'd1;
                            group.entry[0].kind  = KIND_CLOSED;
                            phase_next           = PH_DONE;
                        end
                        else if (item.in_byte < 8'd32)
                        begin
                            group      = error_group(CAUSE_CONTROL);
                            phase_next = PH_DEAD;
                        end
                        else if (item.in_byte == CH_BSL)
                        begin
                            phase_next = PH_ESC;
                        end
                        else
                        begin
                            group = one_entry(data_entry(item.in_byte));
                        end
                    end
                    PH_ESC:
                    begin
                        phase_next = PH_BODY;
                        case (item.in_byte)
                            CH_QUOTE, CH_BSL, CH_SLASH:
                                group = one_entry(data_entry(item.in_byte));
                            8'h62: group = one_entry(data_entry(8'h08));
                            8'h66: group = one_entry(data_entry(8'h0c));
                            8'h6e: group = one_entry(data_entry(8'h0a));
                            8'h72: group = one_entry(data_entry(8'h0d));
                            8'h74: group = one_entry(data_entry(8'h09));
                            CH_U:
                            begin
                                phase_next     = PH_HEX1;
                                hex_accum_next = '0;
                                hex_count_next = '0;
                            end
                            default:
                            begin
                                group      = error_group(CAUSE_BAD_ESC);
                                phase_next = PH_DEAD;
                            end
                        endcase
                    end
                    PH_HEX1, PH_HEX2:
                    begin
                        if (!hex_ok)
                        begin
                            group      = error_group(CAUSE_BAD_HEX);
                            phase_next = PH_DEAD;
                        end
                        else
                        begin
                            hex_accum_next = hex_new;
                            hex_count_next = hex_count_reg + 2'd1;
                            // Fourth digit: act on the full value
                            if (hex_count_reg == 2'd3)
                            begin
                                if (phase_reg == PH_HEX1)
                                begin
                                    if (hex_new[15:10] == HIGH_SURR_TAG)
                                    begin
                                        high_half_next = hex_new[9:0];
                                        phase_next     = PH_LOWBS;
                                    end
                                    else if (hex_new[15:10] == LOW_SURR_TAG)
                                    begin
                                        group      = error_group(CAUSE_BAD_LOW);
                                        phase_next = PH_DEAD;
                                    end
                                    else
                                    begin
                                        group      = utf8_group({5'd0, hex_new});
                                        phase_next = PH_BODY;
                                    end
                                end
                                else if (hex_new[15:10] != LOW_SURR_TAG)
                                begin
                                    group      = error_group(CAUSE_BAD_LOW);
                                    phase_next = PH_DEAD;
                                end
                                else
                                begin
                                    group      = utf8_group(pair_cp);
                                    phase_next = PH_BODY;
                                end
                            end
                        end
                    end
                    PH_LOWBS:
                    begin
                        if (item.in_byte == CH_BSL)
                        begin
                            phase_next = PH_LOWU;
                        end
                        else
                        begin
                            group      = error_group(CAUSE_NO_LOW);
                            phase_next = PH_DEAD;
                        end
                    end
                    PH_LOWU:
                    begin
                        if (item.in_byte == CH_U)
                        begin
                            phase_next     = PH_HEX2;
                            hex_accum_next = '0;
                            hex_count_next = '0;
                        end
                        else
                        begin
                            group      = error_group(CAUSE_NO_LOW);
                            phase_next = PH_DEAD;
                        end
                    end
                    default:
                    begin
                        // Closed or failed: drop text until the next start
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            hex_accum_reg <= '0;
            hex_count_reg <= '0;
            high_half_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            hex_accum_reg <= hex_accum_next;
            hex_count_reg <= hex_count_next;
            high_half_reg <= high_half_next;
        end
    end

endmodule

[rtl/core/jsu_emitter.sv]
// Result register: holds one request's result group and hands it out in order.
// Depends on jsu_pkg.
module jsu_emitter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  jsu_pkg::jsu_group_t group,
    output logic                load_ok,
    output logic                result_valid,
    input  logic                result_ready,
    output jsu_pkg::jsu_out_t   result
);
    import jsu_pkg::*;

    logic       grp_valid_reg;
    jsu_group_t grp_reg;
    logic [1:0] idx_reg;
    logic       at_last;
    logic       take;
    jsu_entry_t cur;

    assign cur     = grp_reg.entry[idx_reg];
    assign at_last = ({1'b0, idx_reg} == (grp_reg.count - 3'd1));
    assign take    = grp_valid_reg && result_ready;
    assign load_ok = !grp_valid_reg || (result_ready && at_last);

    assign result_valid       = grp_valid_reg;
    assign result.kind        = cur.kind;
    assign result.out_byte    = cur.data;
    assign result.error_cause = cur.cause;
    assign result.last        = at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (advance && load_ok)
        begin
            // Groups with no results leave the register empty
            grp_valid_reg <= (group.count != 3'd0);
            idx_reg       <= '0;
        end
        else if (take)
        begin
            if (at_last)
            begin
                grp_valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_ok)
        begin
            grp_reg <= group;
        end
    end

    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({1'b0, idx_reg} < grp_reg.count))
        else $error("result index beyond group count");

    a_cause_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind != KIND_ERROR) |-> (result.error_cause == CAUSE_NONE))
        else $error("error cause set on a non-error result");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == KIND_ERROR) |-> result.last)
        else $error("error result not last of its request");

    a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && load_ok && group.count != 3'd0) |=> (result_valid && idx_reg == 2'd0))
        else $error("loaded group not presented from its first entry");

endmodule

[rtl/core/json_string_unescape_core.sv]
// JSON string unescape core: input register, parser and result register.
// Depends on jsu_pkg, jsu_parser and jsu_emitter.
//
// Decodes one JSON string literal, fed as one request per text byte, into a
// stream of UTF-8 bytes, a close marker or one error result. A request is
// registered in the input register, decoded by the parser, and its 0 to 4
// results land together in the result register, which offers them in order.
// The result register drains one result per cycle while result_ready is high,
// so for requests that yield at most one result the core sustains one request
// per cycle; a \u escape that ends in a 2, 3 or 4 byte UTF-8 sequence holds
// the result register until its last byte is taken and stalls the input side
// meanwhile.
module json_string_unescape_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  jsu_pkg::jsu_in_t  item,
    output logic              result_valid,
    input  logic              result_ready,
    output jsu_pkg::jsu_out_t result
);
    import jsu_pkg::*;

    logic       item_valid_reg;
    jsu_in_t    item_reg;
    logic       load_ok;
    logic       advance;
    jsu_group_t group;

    assign advance    = item_valid_reg && load_ok;
    assign item_ready = !item_valid_reg || load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    jsu_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .group   (group)
    );

    jsu_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .group        (group),
        .load_ok      (load_ok),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[verif/jsu_decode_checker.sv]
// Request/result checker for the JSON string unescape core: decodes every
// accepted request on its own and compares the results in order.
// Depends on jsu_pkg.
module jsu_decode_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  jsu_pkg::jsu_in_t  item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  jsu_pkg::jsu_out_t result,
    output int                mismatches,
    output int                pending
);
    import jsu_pkg::*;

    typedef enum logic [3:0] {
        SCAN_WAIT,
        SCAN_BODY,
        SCAN_ESC,
        SCAN_HEX1,
        SCAN_LOW_BSL,
        SCAN_LOW_U,
        SCAN_HEX2,
        SCAN_DONE,
        SCAN_DEAD
    } scan_t;

    scan_t       scan;
    logic [15:0] hex_val;
    logic [1:0]  digits;
    logic [9:0]  high_bits;
    jsu_out_t    decoded_q[$];
    int          result_no;

    initial mismatches = 0;

    task automatic report_mismatch(string field, int got_v, int want_v);
        $display("mismatch on result %0d: %s got 0x%0h, want 0x%0h",
                 result_no, field, got_v, want_v);
        mismatches++;
    endtask

    task automatic want_result(jsu_kind_t k, logic [7:0] d, jsu_cause_t c);
        jsu_out_t r;
        r.kind        = k;
        r.out_byte    = d;
        r.error_cause = c;
        r.last        = 1'b0;
        decoded_q     = {decoded_q, r};
    endtask

    task automatic want_error(jsu_cause_t c);
        want_result(KIND_ERROR, 8'h00, c);
        scan = SCAN_DEAD;
    endtask

    task automatic want_utf8(logic [20:0] cp);
        if (cp < 21'h80) begin
            want_result(KIND_DATA, cp[7:0], CAUSE_NONE);
        end else if (cp < 21'h800) begin
            want_result(KIND_DATA, {3'b110, cp[10:6]}, CAUSE_NONE);
            want_result(KIND_DATA, {2'b10, cp[5:0]}, CAUSE_NONE);
        end else if (cp < 21'h10000) begin
            want_result(KIND_DATA, {4'b1110, cp[15:12]}, CAUSE_NONE);
            want_result(KIND_DATA, {2'b10, cp[11:6]}, CAUSE_NONE);
            want_result(KIND_DATA, {2'b10, cp[5:0]}, CAUSE_NONE);
        end else begin
            want_result(KIND_DATA, {5'b11110, cp[20:18]}, CAUSE_NONE);
            want_result(KIND_DATA, {2'b10, cp[17:12]}, CAUSE_NONE);
            want_result(KIND_DATA, {2'b10, cp[11:6]}, CAUSE_NONE);
            want_result(KIND_DATA, {2'b10, cp[5:0]}, CAUSE_NONE);
        end
    endtask

    // Bit 4 set means the byte is no hex digit.
    function automatic logic [4:0] hex_nibble(logic [7:0] c);
        logic [7:0] t;
        if (c >= "0" && c <= "9")
            t = c - "0";
        else if (c >= "a" && c <= "f")
            t = c - "a" + 8'd10;
        else if (c >= "A" && c <= "F")
            t = c - "A" + 8'd10;
        else
            t = 8'h10;
        return t[4:0];
    endfunction

    // Shift in one digit; done goes high on the fourth.
    task automatic take_digit(logic [7:0] c, output bit done, output bit bad);
        logic [4:0] n;
        n    = hex_nibble(c);
        bad  = n[4];
        done = 1'b0;
        if (!bad) begin
            hex_val = {hex_val[11:0], n[3:0]};
            done    = (digits == 2'd3);
            digits  = digits + 2'd1;
        end
    endtask

    task automatic scan_byte(logic [7:0] c);
        bit done;
        bit bad;
        case (scan)
            SCAN_WAIT: begin
                if (c == " " || c == "\t" || c == "\r" || c == "\n")
                    ;
                else if (c == CH_QUOTE)
                    scan = SCAN_BODY;
                else
                    want_error(CAUSE_NO_QUOTE);
            end
            SCAN_BODY: begin
                if (c == CH_QUOTE) begin
                    want_result(KIND_CLOSED, 8'h00, CAUSE_NONE);
                    scan = SCAN_DONE;
                end else if (c < 8'h20) begin
                    want_error(CAUSE_CONTROL);
                end else if (c == CH_BSL) begin
                    scan = SCAN_ESC;
                end else begin
                    want_result(KIND_DATA, c, CAUSE_NONE);
                end
            end
            SCAN_ESC: begin
                scan = SCAN_BODY;
                if (c == CH_QUOTE || c == CH_BSL || c == CH_SLASH)
                    want_result(KIND_DATA, c, CAUSE_NONE);
                else if (c == "b")
                    want_result(KIND_DATA, 8'h08, CAUSE_NONE);
                else if (c == "f")
                    want_result(KIND_DATA, 8'h0c, CAUSE_NONE);
                else if (c == "n")
                    want_result(KIND_DATA, 8'h0a, CAUSE_NONE);
                else if (c == "r")
                    want_result(KIND_DATA, 8'h0d, CAUSE_NONE);
                else if (c == "t")
                    want_result(KIND_DATA, 8'h09, CAUSE_NONE);
                else if (c == CH_U) begin
                    scan    = SCAN_HEX1;
                    hex_val = '0;
                    digits  = '0;
                end else
                    want_error(CAUSE_BAD_ESC);
            end
            SCAN_HEX1: begin
                take_digit(c, done, bad);
                if (bad) begin
                    want_error(CAUSE_BAD_HEX);
                end else if (done) begin
                    if (hex_val[15:10] == HIGH_SURR_TAG) begin
                        high_bits = hex_val[9:0];
                        scan      = SCAN_LOW_BSL;
                    end else if (hex_val[15:10] == LOW_SURR_TAG) begin
                        want_error(CAUSE_BAD_LOW);
                    end else begin
                        want_utf8({5'd0, hex_val});
                        scan = SCAN_BODY;
                    end
                end
            end
            SCAN_LOW_BSL: begin
                if (c == CH_BSL) scan = SCAN_LOW_U;
                else want_error(CAUSE_NO_LOW);
            end
            SCAN_LOW_U: begin
                if (c == CH_U) begin
                    scan    = SCAN_HEX2;
                    hex_val = '0;
                    digits  = '0;
                end else
                    want_error(CAUSE_NO_LOW);
            end
            SCAN_HEX2: begin
                take_digit(c, done, bad);
                if (bad) begin
                    want_error(CAUSE_BAD_HEX);
                end else if (done) begin
                    if (hex_val[15:10] != LOW_SURR_TAG) begin
                        want_error(CAUSE_BAD_LOW);
                    end else begin
                        want_utf8(SUPP_BASE + {1'b0, high_bits, hex_val[9:0]});
                        scan = SCAN_BODY;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic clear_scan();
        scan      = SCAN_WAIT;
        hex_val   = '0;
        digits    = '0;
        high_bits = '0;
    endtask

    task automatic decode_request(jsu_in_t req);
        int first;
        first = decoded_q.size();
        case (jsu_op_t'(req.opcode))
            OP_START: clear_scan();
            OP_BYTE:  scan_byte(req.in_byte);
            OP_END: begin
                if (scan == SCAN_WAIT)
                    want_error(CAUSE_NO_QUOTE);
                else if (scan != SCAN_DONE && scan != SCAN_DEAD)
                    want_error(CAUSE_TEXT_END);
            end
            default: ;
        endcase
        // flag the final result of this request
        if (decoded_q.size() > first)
            decoded_q[decoded_q.size() - 1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n) begin
        jsu_out_t want;
        if (!rst_n) begin
            clear_scan();
            decoded_q.delete();
            result_no = 0;
            pending   = 0;
        end else begin
            if (result_valid && result_ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected result", int'(result), 0);
                end else begin
                    want = decoded_q.pop_front();
                    if (result.kind != want.kind)
                        report_mismatch("kind", int'(result.kind), int'(want.kind));
                    if (result.out_byte != want.out_byte)
                        report_mismatch("out_byte", int'(result.out_byte),
                                        int'(want.out_byte));
                    if (result.error_cause != want.error_cause)
                        report_mismatch("error_cause", int'(result.error_cause),
                                        int'(want.error_cause));
                    if (result.last != want.last)
                        report_mismatch("last", int'(result.last), int'(want.last));
                end
                result_no++;
            end
            if (item_valid && item_ready)
                decode_request(item);
            pending = decoded_q.size();
        end
    end

endmodule

[verif/tb_top.sv]
// Top of the unescape core testbench: clock, reset, request and result
// traffic, watchdog and verdict. Depends on jsu_pkg, the core and
// jsu_decode_checker.
module tb_top;
    import jsu_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int TARGET_ITEMS = 270;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 400;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     item_valid   = 1'b0;
    logic     item_ready;
    jsu_in_t  item         = '0;
    logic     result_valid;
    logic     result_ready = 1'b0;
    jsu_out_t result;

    int mismatches;
    int pending;
    int n_items = 0;
    int quiet   = 0;
    bit steady  = 1'b0;

    json_string_unescape_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    jsu_decode_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always #HALF_PERIOD clk = ~clk;

    // End the run when no request or result moves for too long.
    always @(posedge clk) begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_req(jsu_op_t op, logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{opcode: op, in_byte: b};
        do @(posedge clk); while (!item_ready);
        n_items++;
    endtask

    task automatic send_op(jsu_op_t op);
        send_req(op, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++) send_req(OP_BYTE, s[k]);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return "0" + n;
        return ($urandom_range(0, 1) ? "a" : "A") + (n - 4'd10);
    endfunction

    function automatic logic [15:0] pick_in_range(logic [15:0] lo, logic [15:0] hi);
        case ($urandom_range(0, 5))
            0:       return lo;
            1:       return hi;
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic send_uesc(logic [15:0] v);
        send_req(OP_BYTE, CH_BSL);
        send_req(OP_BYTE, CH_U);
        for (int k = 3; k >= 0; k--) send_req(OP_BYTE, hex_char(v[k*4 +: 4]));
    endtask

    task automatic send_piece();
        logic [7:0] b;
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5, 6: begin
                case ($urandom_range(0, 7))
                    0:       b = 8'h20;
                    1:       b = 8'hff;
                    default: do b = 8'($urandom_range(32, 255));
                             while (b == CH_QUOTE || b == CH_BSL);
                endcase
                send_req(OP_BYTE, b);
            end
            7, 8: begin
                case ($urandom_range(0, 7))
                    0:       b = CH_QUOTE;
                    1:       b = CH_BSL;
                    2:       b = CH_SLASH;
                    3:       b = "b";
                    4:       b = "f";
                    5:       b = "n";
                    6:       b = "r";
                    default: b = "t";
                endcase
                send_req(OP_BYTE, CH_BSL);
                send_req(OP_BYTE, b);
            end
            9, 10, 11: begin
                // one, two or three byte encodings around their bounds
                case ($urandom_range(0, 3))
                    0:       send_uesc(pick_in_range(16'h0000, 16'h007f));
                    1:       send_uesc(pick_in_range(16'h0080, 16'h07ff));
                    2:       send_uesc(pick_in_range(16'h0800, 16'hd7ff));
                    default: send_uesc(pick_in_range(16'he000, 16'hffff));
                endcase
            end
            12, 13, 14: begin
                send_uesc(pick_in_range(16'hd800, 16'hdbff));
                send_uesc(pick_in_range(16'hdc00, 16'hdfff));
            end
            default: send_op(OP_RSVD);
        endcase
    endtask

    task automatic send_fault();
        logic [7:0]  b;
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0: send_req(OP_BYTE, 8'(pick_in_range(16'h0000, 16'h001f)));
            1: begin
                do b = 8'($urandom_range(0, 255));
                while (b == CH_QUOTE || b == CH_BSL || b == CH_SLASH || b == CH_U ||
                       b == "b" || b == "f" || b == "n" || b == "r" || b == "t");
                send_req(OP_BYTE, CH_BSL);
                send_req(OP_BYTE, b);
            end
            2: begin
                // broken digit in a lone escape or in the low half of a pair
                if ($urandom_range(0, 1)) send_uesc(pick_in_range(16'hd800, 16'hdbff));
                send_req(OP_BYTE, CH_BSL);
                send_req(OP_BYTE, CH_U);
                repeat ($urandom_range(0, 3))
                    send_req(OP_BYTE, hex_char(4'($urandom_range(0, 15))));
                case ($urandom_range(0, 11))
                    0:       b = "/";
                    1:       b = ":";
                    2:       b = "@";
                    3:       b = "G";
                    4:       b = 8'h60;  // just below 'a'
                    5:       b = "g";
                    default: do b = 8'($urandom_range(0, 255));
                             while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
                                    (b >= "A" && b <= "F"));
                endcase
                send_req(OP_BYTE, b);
            end
            3: send_uesc(pick_in_range(16'hdc00, 16'hdfff));
            4: begin
                send_uesc(pick_in_range(16'hd800, 16'hdbff));
                do b = 8'($urandom_range(0, 255)); while (b == CH_BSL);
                send_req(OP_BYTE, b);
            end
            5: begin
                send_uesc(pick_in_range(16'hd800, 16'hdbff));
                send_req(OP_BYTE, CH_BSL);
                do b = 8'($urandom_range(0, 255)); while (b == CH_U);
                send_req(OP_BYTE, b);
            end
            6: begin
                send_uesc(pick_in_range(16'hd800, 16'hdbff));
                case ($urandom_range(0, 3))
                    0:       v = 16'hdbff;
                    1:       v = 16'he000;
                    default: do v = 16'($urandom_range(0, 65535));
                             while (v[15:10] == LOW_SURR_TAG);
                endcase
                send_uesc(v);
            end
            default: begin
                // text ends, possibly in the middle of an escape
                case ($urandom_range(0, 3))
                    1: send_req(OP_BYTE, CH_BSL);
                    2: begin
                        send_req(OP_BYTE, CH_BSL);
                        send_req(OP_BYTE, CH_U);
                        repeat ($urandom_range(0, 3))
                            send_req(OP_BYTE, hex_char(4'($urandom_range(0, 15))));
                    end
                    3: send_uesc(pick_in_range(16'hd800, 16'hdbff));
                    default: ;
                endcase
                send_op(OP_END);
            end
        endcase
    endtask

    task automatic send_string();
        int         n_pieces;
        int         fault_at;
        logic [7:0] b;
        steady   = ($urandom_range(0, 3) == 0);
        send_op(OP_START);
        n_pieces = $urandom_range(0, 2);
        for (int i = 0; i < n_pieces; i++) begin
            case ($urandom_range(0, 3))
                0:       send_req(OP_BYTE, " ");
                1:       send_req(OP_BYTE, "\t");
                2:       send_req(OP_BYTE, "\r");
                default: send_req(OP_BYTE, "\n");
            endcase
        end
        if ($urandom_range(0, 15) == 0) begin
            // never opened
            if ($urandom_range(0, 1)) begin
                send_op(OP_END);
            end else begin
                do b = 8'($urandom_range(0, 255));
                while (b == CH_QUOTE || b == " " || b == "\t" || b == "\r" || b == "\n");
                send_req(OP_BYTE, b);
            end
        end else begin
            send_req(OP_BYTE, CH_QUOTE);
            n_pieces = $urandom_range(0, 6);
            fault_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_pieces) : -1;
            for (int i = 0; i < n_pieces && i != fault_at; i++) send_piece();
            if (fault_at >= 0)
                send_fault();
            else if ($urandom_range(0, 7) == 0)
                send_op(OP_END);
            else
                send_req(OP_BYTE, CH_QUOTE);
        end
        // trailing traffic that the core must swallow
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 2))
                    0:       send_req(OP_BYTE, 8'($urandom_range(0, 255)));
                    1:       send_op(OP_END);
                    default: send_op(OP_RSVD);
                endcase
            end
        end
    endtask

    initial begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(OP_START);
        send_op(OP_END);
        send_op(OP_START);
        send_op(OP_RSVD);
        send_text(" \t\r\n\"");
        send_req(OP_BYTE, 8'hff);
        send_req(OP_BYTE, 8'h20);
        send_text("\\udc00x");
        send_op(OP_END);
        send_op(OP_START);
        send_text("\"\\q");
        send_op(OP_START);
        send_req(OP_BYTE, CH_QUOTE);
        send_req(OP_BYTE, 8'h00);

        while (n_items < TARGET_ITEMS) send_string();
        item_valid <= 1'b0;

        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin : receiver
        int stall;
        int taken;
        bit eager;
        taken = 0;
        eager = 1'b0;
        wait (rst_n);
        forever begin
            if (taken % 32 == 0) eager = ($urandom_range(0, 3) == 0);
            stall = eager ? 0 : $urandom_range(0, 13);
            // long hold-off so the core backs up into its input
            if (taken == HOLD_AT) stall = HOLD_CYCLES;
            if (stall > 0) begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            taken++;
        end
    end

endmodule
